/* hw/rtl/khi_pkg.sv */
// Package for the key-to-position hash indexer: item classes, queue entry
// and result types, and the fixed field widths shared by all modules.
// No dependencies.
package khi_pkg;

  localparam int KeyW = 64;
  localparam int PosW = 11;
  localparam int OpW = 2;

  localparam int DefCapacity = 1024;
  localparam int DefSlots = 2048;

  // Opcodes on the input channel
  typedef enum logic [OpW-1:0] {
    OP_CLEAR  = 2'd0,
    OP_INSERT = 2'd1,
    OP_LOOKUP = 2'd2,
    OP_NOP    = 2'd3
  } op_e;

  // Class of an item after the front end has decoded it
  typedef enum logic [1:0] {
    K_CLEAR,
    K_INSERT,
    K_LOOKUP,
    K_IGNORE
  } kind_e;

  // One queued request
  typedef struct packed {
    kind_e           kind;
    logic [KeyW-1:0] key;
  } req_t;

  // One result
  typedef struct packed {
    logic signed [PosW-1:0] position;
    logic                   found;
    logic                   duplicate_seen;
    logic                   table_full;
  } rsp_t;

  // Position -1 in the output field
  localparam logic signed [PosW-1:0] PosNone = '1;

endpackage

/* hw/rtl/khi_if.sv */
// Valid/ready channel interfaces of the hash indexer: request and result.
// Depends on khi_pkg.
interface khi_req_if
  import khi_pkg::*;
();
  logic                   valid;
  logic                   ready;
  logic [OpW-1:0]         op;
  logic signed [KeyW-1:0] key;

  modport source (output valid, output op, output key, input ready);
  modport sink   (input valid, input op, input key, output ready);
endinterface

interface khi_rsp_if
  import khi_pkg::*;
();
  logic                   valid;
  logic                   ready;
  logic signed [PosW-1:0] position;
  logic                   found;
  logic                   duplicate_seen;
  logic                   table_full;

  modport source (output valid, output position, output found,
                  output duplicate_seen, output table_full, input ready);
  modport sink   (input valid, input position, input found,
                  input duplicate_seen, input table_full, output ready);
endinterface

/* hw/rtl/khi_front.sv */
// Front end of the hash indexer: takes request transfers and decodes the
// opcode into an item class for the queue. Depends on khi_pkg, khi_if.
module khi_front
  import khi_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  khi_req_if.sink         in_i,
  input  logic            q_full_i,
  output logic            push_o,
  output req_t            push_data_o
);

  kind_e kind;

  // Opcode decode
  always_comb begin
    case (op_e'(in_i.op))
      OP_CLEAR:  kind = K_CLEAR;
      OP_INSERT: kind = K_INSERT;
      OP_LOOKUP: kind = K_LOOKUP;
      default:   kind = K_IGNORE;
    endcase
  end

  assign in_i.ready       = !q_full_i;
  assign push_o           = in_i.valid && !q_full_i;
  assign push_data_o.kind = kind;
  assign push_data_o.key  = in_i.key;

  // A transfer is never taken into a full queue
  assert property (@(posedge clk_i) disable iff (!rst_ni) q_full_i |-> !push_o)
    else $error("push into full queue");

endmodule

/* hw/rtl/khi_queue.sv */
// Two-entry request queue between the front and back ends of the indexer.
// Depends on khi_pkg.
module khi_queue
  import khi_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  req_t push_data_i,
  input  logic pop_i,
  output logic full_o,
  output logic valid_o,
  output req_t data_o
);

  req_t       mem_q [2];
  logic       wr_q, wr_d;
  logic       rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;

  // Pointers and fill count
  always_comb begin
    wr_d  = push_i ? !wr_q : wr_q;
    rd_d  = pop_i ? !rd_q : rd_q;
    cnt_d = cnt_q + 2'(push_i) - 2'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  assign full_o  = cnt_q == 2'd2;
  assign valid_o = cnt_q != 2'd0;
  assign data_o  = mem_q[rd_q];

  assert property (@(posedge clk_i) disable iff (!rst_ni) pop_i |-> valid_o)
    else $error("pop from empty queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q != 2'd3)
    else $error("queue count overflow");

endmodule

/* hw/rtl/khi_back.sv */
// Back end of the indexer: slot memory, linear-probe search, clear sweep
// and the result register. Depends on khi_pkg, khi_if.
module khi_back
  import khi_pkg::*;
#(
  parameter int Capacity = DefCapacity,
  parameter int Slots    = DefSlots
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      q_valid_i,
  input  req_t      q_data_i,
  output logic      pop_o,
  khi_rsp_if.source out_o
);

  localparam int IdxW = $clog2(Slots);
  localparam int SpW  = $clog2(Capacity);
  localparam int NpW  = $clog2(Capacity + 1);
  localparam int EntW = 1 + KeyW + SpW;
  localparam int NCh  = (KeyW + IdxW - 1) / IdxW;
  localparam int PadW = NCh * IdxW;

  localparam logic [2:0] S_SWEEP = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_WAIT  = 3'd2;
  localparam logic [2:0] S_CHK   = 3'd3;

  logic [2:0]      state_q, state_d;
  logic [IdxW-1:0] sweep_q, sweep_d;
  logic [IdxW-1:0] addr_q, addr_d;
  logic [IdxW-1:0] cnt_q, cnt_d;
  logic [NpW-1:0]  np_q, np_d;
  logic            dup_q, dup_d;
  kind_e           kind_q, kind_d;
  logic [KeyW-1:0] key_q, key_d;
  logic            ov_q, ov_d;
  rsp_t            rsp_q, rsp_d;

  logic [EntW-1:0] mem [Slots];
  logic [EntW-1:0] rd_q;
  logic            we;
  logic [IdxW-1:0] wa;
  logic [EntW-1:0] wd;

  logic            e_valid;
  logic [KeyW-1:0] e_key;
  logic [SpW-1:0]  e_pos;
  logic [PosW-1:0] np_out;
  logic [PosW-1:0] ep_out;
  logic [NpW+PosW-1:0] np_ext;
  logic [SpW+PosW-1:0] ep_ext;

  // Home slot: xor fold of the key, then one conditional subtract
  function automatic logic [IdxW-1:0] home_slot(input logic [KeyW-1:0] k);
    logic [PadW-1:0] kp;
    logic [IdxW-1:0] h;
    kp = PadW'(k);
    h  = '0;
    for (int i = 0; i < NCh; i++) begin
      h = h ^ kp[i*IdxW +: IdxW];
    end
    if ({1'b0, h} >= (IdxW+1)'(Slots)) begin
      h = IdxW'({1'b0, h} - (IdxW+1)'(Slots));
    end
    return h;
  endfunction

  assign e_valid = rd_q[EntW-1];
  assign e_key   = rd_q[EntW-2 -: KeyW];
  assign e_pos   = rd_q[SpW-1:0];
  assign np_ext  = {{PosW{1'b0}}, np_q};
  assign ep_ext  = {{PosW{1'b0}}, e_pos};
  assign np_out  = np_ext[PosW-1:0];
  assign ep_out  = ep_ext[PosW-1:0];

  // Sequencer
  always_comb begin
    state_d = state_q;
    sweep_d = sweep_q;
    addr_d  = addr_q;
    cnt_d   = cnt_q;
    np_d    = np_q;
    dup_d   = dup_q;
    kind_d  = kind_q;
    key_d   = key_q;
    ov_d    = ov_q && !out_o.ready;
    rsp_d   = rsp_q;
    pop_o   = 1'b0;
    we      = 1'b0;
    wa      = addr_q;
    wd      = {1'b1, key_q, np_q[SpW-1:0]};
    case (state_q)
      S_SWEEP: begin
        we      = 1'b1;
        wa      = sweep_q;
        wd      = '0;
        sweep_d = sweep_q + 1'b1;
        if (sweep_q == IdxW'(Slots - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (q_valid_i && !ov_q) begin
          pop_o  = 1'b1;
          kind_d = q_data_i.kind;
          key_d  = q_data_i.key;
          addr_d = home_slot(q_data_i.key);
          cnt_d  = '0;
          case (q_data_i.kind)
            K_CLEAR: begin
              np_d    = '0;
              dup_d   = 1'b0;
              ov_d    = 1'b1;
              rsp_d   = '{PosNone, 1'b0, 1'b0, 1'b0};
              sweep_d = '0;
              state_d = S_SWEEP;
            end
            K_INSERT: begin
              if (np_q >= NpW'(Capacity)) begin
                ov_d  = 1'b1;
                rsp_d = '{PosNone, 1'b0, dup_q, 1'b1};
              end else begin
                state_d = S_WAIT;
              end
            end
            K_LOOKUP: state_d = S_WAIT;
            default: begin
              ov_d  = 1'b1;
              rsp_d = '{PosNone, 1'b0, dup_q, 1'b0};
            end
          endcase
        end
      end
      S_WAIT: state_d = S_CHK;
      S_CHK: begin
        if (!e_valid) begin
          state_d = S_IDLE;
          ov_d    = 1'b1;
          if (kind_q == K_INSERT) begin
            we    = 1'b1;
            np_d  = np_q + 1'b1;
            rsp_d = '{np_out, 1'b0, dup_q, 1'b0};
          end else begin
            rsp_d = '{PosNone, 1'b0, dup_q, 1'b0};
          end
        end else if (e_key == key_q) begin
          state_d = S_IDLE;
          ov_d    = 1'b1;
          if (kind_q == K_INSERT) begin
            we    = 1'b1;
            np_d  = np_q + 1'b1;
            dup_d = 1'b1;
            rsp_d = '{np_out, 1'b1, 1'b1, 1'b0};
          end else begin
            rsp_d = '{ep_out, 1'b1, dup_q, 1'b0};
          end
        end else if (cnt_q == IdxW'(Slots - 1)) begin
          state_d = S_IDLE;
          ov_d    = 1'b1;
          rsp_d   = '{PosNone, 1'b0, dup_q, kind_q == K_INSERT};
        end else begin
          addr_d  = (addr_q == IdxW'(Slots - 1)) ? '0 : addr_q + 1'b1;
          cnt_d   = cnt_q + 1'b1;
          state_d = S_WAIT;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_SWEEP;
      sweep_q <= '0;
      np_q    <= '0;
      dup_q   <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      sweep_q <= sweep_d;
      np_q    <= np_d;
      dup_q   <= dup_d;
      ov_q    <= ov_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    addr_q <= addr_d;
    cnt_q  <= cnt_d;
    kind_q <= kind_d;
    key_q  <= key_d;
    rsp_q  <= rsp_d;
  end

  // Slot memory: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_q <= mem[addr_q];
  end

  assign out_o.valid          = ov_q;
  assign out_o.position       = rsp_q.position;
  assign out_o.found          = rsp_q.found;
  assign out_o.duplicate_seen = rsp_q.duplicate_seen;
  assign out_o.table_full     = rsp_q.table_full;

  assert property (@(posedge clk_i) disable iff (!rst_ni) np_q <= NpW'(Capacity))
    else $error("position counter past capacity");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   state_q == S_SWEEP |-> !pop_o)
    else $error("request taken during sweep");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   ov_q && rsp_q.table_full |-> rsp_q.position == PosNone)
    else $error("rejected insert with a position");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   $rose(dup_q) |-> $past(state_q) == S_CHK)
    else $error("duplicate flag set outside a probe");

endmodule

/* hw/rtl/key_to_position_hash_indexer.sv */
// Top level of the key-to-position hash indexer: front end, request queue
// and back end. Depends on khi_pkg, khi_if, khi_front, khi_queue, khi_back.
//
// Usage:
//   in_i carries op (clear, insert, look up) and a 64-bit key; out_o
//   returns one result per request: position, found, duplicate_seen and
//   table_full. A transfer happens when valid and ready are both high.
//   Requests enter a two-entry queue; ready drops only when it is full.
//   A lookup or insert reads each probed slot in turn, through a wait
//   state and a check state; a result register holds the result until taken.
//   A rejected insert or an ignored op is answered from the idle state.
//   A clear answers at once and then sweeps the slot memory, one slot a
//   cycle, before the next request is served.
//   After reset the same sweep runs; requests are queued meanwhile. If the
//   receiver stalls, the result waits in its register, the back end holds,
//   and the queue fills before ready drops.
//   Throughput: one request at a time; none is taken while a result waits.
module key_to_position_hash_indexer
  import khi_pkg::*;
#(
  parameter int Capacity = DefCapacity,
  parameter int Slots    = DefSlots
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  khi_req_if.sink   in_i,
  khi_rsp_if.source out_o
);

  logic q_full, push, pop, q_valid;
  req_t push_data, q_data;

  khi_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .q_full_i    (q_full),
    .push_o      (push),
    .push_data_o (push_data)
  );

  khi_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .full_o      (q_full),
    .valid_o     (q_valid),
    .data_o      (q_data)
  );

  khi_back #(
    .Capacity (Capacity),
    .Slots    (Slots)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_data_i  (q_data),
    .pop_o     (pop),
    .out_o     (out_o)
  );

endmodule

/* tb/tb.sv */
// Self-checking testbench for key_to_position_hash_indexer: directed table
// and random traffic, checked against a local table model.
// Depends on khi_pkg, khi_if and the indexer RTL.
`timescale 1ns / 100ps

module tb;
  import khi_pkg::*;

  localparam int Capacity  = DefCapacity;
  localparam int Slots     = DefSlots;
  localparam int StallMax  = 11;
  localparam int IdleLimit = 60000;
  localparam int NumRandom = 720;
  localparam int KeyPool   = 48;

  logic clk_i;
  logic rst_ni;

  khi_req_if req_ch ();
  khi_rsp_if rsp_ch ();

  key_to_position_hash_indexer #(
    .Capacity(Capacity),
    .Slots   (Slots)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (req_ch),
    .out_o (rsp_ch)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Local copy of the table
  logic [KeyW-1:0] tbl_key  [Slots];
  logic [9:0]      tbl_pos  [Slots];
  logic            tbl_used [Slots];
  int unsigned     tbl_next;
  logic            tbl_dup;

  rsp_t        pending_rsp[$];
  int          fail_count;
  int          idle_cycles;
  logic [KeyW-1:0] key_pool[KeyPool];

  // Home slot of the local table; results do not depend on the slot choice
  function automatic int unsigned home_of(logic [KeyW-1:0] k);
    k = k ^ (k >> 33);
    k = k * 64'hFF51AFD7ED558CCD;
    k = k ^ (k >> 33);
    k = k * 64'hC4CEB9FE1A85EC53;
    k = k ^ (k >> 33);
    return 32'(k % Slots);
  endfunction

  // Linear probe: 1 on hit; slot is the hit, the first free slot, or Slots
  function automatic bit probe_for(logic [KeyW-1:0] k, output int unsigned slot);
    int unsigned s;
    s = home_of(k);
    for (int n = 0; n < Slots; n++) begin
      if (!tbl_used[s]) begin
        slot = s;
        return 1'b0;
      end
      if (tbl_key[s] == k) begin
        slot = s;
        return 1'b1;
      end
      s = (s + 1 == Slots) ? 0 : s + 1;
    end
    slot = Slots;
    return 1'b0;
  endfunction

  // Apply one item to the local table and return its result
  function automatic rsp_t index_item(op_e op, logic [KeyW-1:0] k);
    rsp_t r;
    int unsigned s;
    bit hit;
    r.position = PosNone;
    r.found = 1'b0;
    r.table_full = 1'b0;
    case (op)
      OP_CLEAR: begin
        for (int i = 0; i < Slots; i++) tbl_used[i] = 1'b0;
        tbl_next = 0;
        tbl_dup = 1'b0;
      end
      OP_INSERT: begin
        if (tbl_next >= Capacity) begin
          r.table_full = 1'b1;
        end else begin
          hit = probe_for(k, s);
          if (hit) begin
            tbl_pos[s] = tbl_next[9:0];
            r.position = tbl_next[PosW-1:0];
            r.found = 1'b1;
            tbl_dup = 1'b1;
            tbl_next++;
          end else if (s >= Slots) begin
            r.table_full = 1'b1;
          end else begin
            tbl_key[s] = k;
            tbl_pos[s] = tbl_next[9:0];
            tbl_used[s] = 1'b1;
            r.position = tbl_next[PosW-1:0];
            tbl_next++;
          end
        end
      end
      OP_LOOKUP: begin
        hit = probe_for(k, s);
        if (hit) begin
          r.position = {1'b0, tbl_pos[s]};
          r.found = 1'b1;
        end
      end
      default: ;
    endcase
    r.duplicate_seen = tbl_dup;
    return r;
  endfunction

  task automatic report(string what, int got, int want);
    $display("mismatch: %s got %0d expected %0d", what, got, want);
    fail_count++;
  endtask

  // Send one request; queue the typed result if given, else the predicted one
  bit quiet_run;
  task automatic send_item(op_e op, logic [KeyW-1:0] k, bit typed = 1'b0,
                           rsp_t want = '0);
    int idle;
    rsp_t r;
    if ($urandom_range(0, 15) == 0) quiet_run = ~quiet_run;
    idle = quiet_run ? 0 : $urandom_range(0, StallMax);
    if (idle > 0) begin
      req_ch.valid <= 1'b0;
      repeat (idle) @(posedge clk_i);
    end
    req_ch.valid <= 1'b1;
    req_ch.op    <= op;
    req_ch.key   <= k;
    do @(posedge clk_i); while (!req_ch.ready);
    r = index_item(op, k);
    pending_rsp.push_back(typed ? want : r);
  endtask

  // Result side: check each transfer, stall at random
  int stall_left;
  always @(posedge clk_i) begin
    rsp_t want;
    if (rst_ni && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_rsp.size() == 0) begin
        report("unexpected result", 1, 0);
      end else begin
        want = pending_rsp.pop_front();
        if (rsp_ch.position !== want.position)
          report("position", rsp_ch.position, want.position);
        if (rsp_ch.found !== want.found)
          report("found", rsp_ch.found, want.found);
        if (rsp_ch.duplicate_seen !== want.duplicate_seen)
          report("duplicate_seen", rsp_ch.duplicate_seen, want.duplicate_seen);
        if (rsp_ch.table_full !== want.table_full)
          report("table_full", rsp_ch.table_full, want.table_full);
      end
      stall_left = quiet_run ? 0 : $urandom_range(0, StallMax);
    end
    if (stall_left > 0) begin
      rsp_ch.ready <= 1'b0;
      stall_left--;
    end else begin
      rsp_ch.ready <= 1'b1;
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("** key_to_position_hash_indexer: FAILED **");
      $finish;
    end
  end

  // Directed rows: typed results only where obvious
  typedef struct {
    op_e             op;
    logic [KeyW-1:0] key;
    bit              typed;
    rsp_t            want;
  } row_t;

  localparam logic [KeyW-1:0] KMin = 64'h8000_0000_0000_0000;
  localparam logic [KeyW-1:0] KMax = 64'h7FFF_FFFF_FFFF_FFFF;

  row_t rows[] = '{
    '{OP_LOOKUP, KMin, 1, '{PosNone, 0, 0, 0}},
    '{OP_INSERT, KMin, 1, '{11'sd0, 0, 0, 0}},
    '{OP_INSERT, KMax, 1, '{11'sd1, 0, 0, 0}},
    '{OP_LOOKUP, KMax, 1, '{11'sd1, 1, 0, 0}},
    '{OP_INSERT, KMin, 1, '{11'sd2, 1, 1, 0}},
    '{OP_LOOKUP, KMin, 1, '{11'sd2, 1, 1, 0}},
    '{OP_NOP,    KMax, 1, '{PosNone, 0, 1, 0}},
    '{OP_CLEAR,  KMax, 1, '{PosNone, 0, 0, 0}},
    '{OP_LOOKUP, KMax, 1, '{PosNone, 0, 0, 0}},
    '{OP_INSERT, 64'h0, 1, '{11'sd0, 0, 0, 0}},
    '{OP_INSERT, '1, 1, '{11'sd1, 0, 0, 0}},
    '{OP_INSERT, 64'h5555_5555_5555_5555, 0, '{default: 0}},
    '{OP_INSERT, 64'hAAAA_AAAA_AAAA_AAAA, 0, '{default: 0}},
    '{OP_LOOKUP, 64'h5555_5555_5555_5555, 0, '{default: 0}},
    '{OP_LOOKUP, 64'hAAAA_AAAA_AAAA_AAAA, 0, '{default: 0}},
    '{OP_LOOKUP, 64'h1, 0, '{default: 0}},
    '{OP_INSERT, 64'h0, 0, '{default: 0}},
    '{OP_LOOKUP, '1, 0, '{default: 0}},
    '{OP_NOP,    '1, 0, '{default: 0}}
  };

  // Stimulus
  initial begin
    int pick;
    logic [KeyW-1:0] k;
    fail_count = 0;
    idle_cycles = 0;
    stall_left = 0;
    quiet_run = 1'b0;
    tbl_next = 0;
    tbl_dup = 1'b0;
    for (int i = 0; i < Slots; i++) tbl_used[i] = 1'b0;
    for (int i = 0; i < KeyPool; i++) key_pool[i] = {$urandom, $urandom};
    key_pool[0] = KMin;
    key_pool[1] = KMax;
    req_ch.valid = 1'b0;
    req_ch.op = OP_NOP;
    req_ch.key = '0;
    rsp_ch.ready = 1'b0;
    rst_ni = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) send_item(rows[i].op, rows[i].key, rows[i].typed, rows[i].want);
    send_item(OP_CLEAR, '0, 1'b1, '{PosNone, 0, 0, 0});

    // Random traffic over a small key pool plus fresh keys
    for (int i = 0; i < NumRandom; i++) begin
      pick = $urandom_range(0, 99);
      k = ($urandom_range(0, 3) == 0) ? {$urandom, $urandom}
                                      : key_pool[$urandom_range(0, KeyPool - 1)];
      if (pick < 2) send_item(OP_CLEAR, k);
      else if (pick < 6) send_item(OP_NOP, k);
      else if (pick < 52) send_item(OP_INSERT, k);
      else send_item(OP_LOOKUP, k);
    end
    req_ch.valid <= 1'b0;

    while (pending_rsp.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("** key_to_position_hash_indexer: PASSED **");
    end else begin
      $display("** key_to_position_hash_indexer: FAILED **");
    end
    $finish;
  end

endmodule
